@@ hdl/skat_pkg.sv @@
`default_nettype none

package skat_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W     = 27;
  localparam int GRADE_W   = 5;
  localparam int CRED_W    = 10;
  localparam int PROD_W    = GRADE_W + CRED_W;
  localparam int COUNT_W   = 16;
  localparam int WSUM_W    = 32;
  localparam int CSUM_W    = 24;
  localparam int IDX_OUT_W = 8;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_LOOKUP_HIT = 3'd3,
    ST_LOOKUP_MISS = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] cnt;
    logic [WSUM_W-1:0]  wsum;
    logic [CSUM_W-1:0]  csum;
  } ent_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] idx;
    logic [COUNT_W-1:0]   cnt;
    logic [WSUM_W-1:0]    wsum;
    logic [CSUM_W-1:0]    csum;
  } res_t;

  localparam int ENT_W = $bits(ent_t);

  // low bits of a table position, zero padded for small tables
  function automatic logic [IDX_OUT_W-1:0] out_idx(input logic [IDX_W-1:0] p);
    logic [IDX_W+IDX_OUT_W-1:0] tmp;
    tmp = {{IDX_OUT_W{1'b0}}, p};
    return tmp[IDX_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/skat_ram.sv @@
`default_nettype none

module skat_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/skat_engine.sv @@
`default_nettype none

module skat_engine
  import skat_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic [KEY_W-1:0]   in_record_key,
  input  wire logic [GRADE_W-1:0] in_grade,
  input  wire logic [CRED_W-1:0]  in_credits,
  output logic                    rd_en,
  output logic      [IDX_W-1:0]   rd_addr,
  input  wire logic [ENT_W-1:0]   rd_data,
  output logic                    wr_en,
  output logic      [IDX_W-1:0]   wr_addr,
  output logic      [ENT_W-1:0]   wr_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output res_t                    res
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SRCH = 8'b0000_0010,
    S_CMP  = 8'b0000_0100,
    S_HIT  = 8'b0000_1000,
    S_MISS = 8'b0001_0000,
    S_SHRD = 8'b0010_0000,
    S_SHWR = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [CRED_W-1:0]   cred_r, cred_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0]    mid_r, mid_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  res_t                res_r, res_nxt;

  always_comb begin
    ent_t               ent;
    ent_t               upd;
    logic [CNT_W-1:0]   mid;
    logic [COUNT_W:0]   cs;
    logic [WSUM_W:0]    ws;
    logic [CSUM_W:0]    ks;

    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    prod_nxt  = prod_r;
    cred_nxt  = cred_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = mid_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = rd_data;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    ent = ent_t'(rd_data);
    mid = lo_r + ((hi_r - lo_r) >> 1);
    cs  = {1'b0, ent.cnt} + (COUNT_W + 1)'(1);
    ws  = {1'b0, ent.wsum} + (WSUM_W + 1)'(prod_r);
    ks  = {1'b0, ent.csum} + (CSUM_W + 1)'(cred_r);
    upd.key  = ent.key;
    upd.cnt  = cs[COUNT_W] ? {COUNT_W{1'b1}} : cs[COUNT_W-1:0];
    upd.wsum = ws[WSUM_W] ? {WSUM_W{1'b1}} : ws[WSUM_W-1:0];
    upd.csum = ks[CSUM_W] ? {CSUM_W{1'b1}} : ks[CSUM_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          key_nxt   = in_record_key;
          prod_nxt  = {{CRED_W{1'b0}}, in_grade} * {{GRADE_W{1'b0}}, in_credits};
          cred_nxt  = in_credits;
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = mid[IDX_W-1:0];
          mid_nxt   = mid[IDX_W-1:0];
          state_nxt = S_CMP;
        end else begin
          pos_nxt   = lo_r[IDX_W-1:0];
          state_nxt = S_MISS;
        end
      end
      S_CMP: begin
        if (ent.key == key_r) begin
          pos_nxt   = mid_r;
          state_nxt = S_HIT;
        end else begin
          if (key_r > ent.key) begin
            lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
          end else begin
            hi_nxt = CNT_W'(mid_r);
          end
          state_nxt = S_SRCH;
        end
      end
      S_HIT: begin
        res_nxt.idx = out_idx(pos_r);
        if (cmd_r == CMD_LOOKUP) begin
          res_nxt.status = ST_LOOKUP_HIT;
          res_nxt.cnt    = ent.cnt;
          res_nxt.wsum   = ent.wsum;
          res_nxt.csum   = ent.csum;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = pos_r;
          wr_data        = upd;
          res_nxt.status = ST_UPDATED;
          res_nxt.cnt    = upd.cnt;
          res_nxt.wsum   = upd.wsum;
          res_nxt.csum   = upd.csum;
        end
        state_nxt = S_EMIT;
      end
      S_MISS: begin
        if (cmd_r == CMD_LOOKUP || cnt_r == CNT_W'(TABLE_DEPTH)) begin
          res_nxt.status = (cmd_r == CMD_LOOKUP) ? ST_LOOKUP_MISS : ST_DROPPED;
          res_nxt.idx    = '0;
          res_nxt.cnt    = '0;
          res_nxt.wsum   = '0;
          res_nxt.csum   = '0;
          state_nxt      = S_EMIT;
        end else begin
          i_nxt     = cnt_r[IDX_W-1:0];
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        if (i_r > pos_r) begin
          rd_en     = 1'b1;
          rd_addr   = i_r - IDX_W'(1);
          state_nxt = S_SHWR;
        end else begin
          upd.key        = key_r;
          upd.cnt        = COUNT_W'(1);
          upd.wsum       = WSUM_W'(prod_r);
          upd.csum       = CSUM_W'(cred_r);
          wr_en          = 1'b1;
          wr_addr        = pos_r;
          wr_data        = upd;
          cnt_nxt        = cnt_r + CNT_W'(1);
          res_nxt.status = ST_INSERTED;
          res_nxt.idx    = out_idx(pos_r);
          res_nxt.cnt    = upd.cnt;
          res_nxt.wsum   = upd.wsum;
          res_nxt.csum   = upd.csum;
          state_nxt      = S_EMIT;
        end
      end
      S_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = i_r;
        wr_data   = rd_data;
        i_nxt     = i_r - IDX_W'(1);
        state_nxt = S_SHRD;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    cred_r <= cred_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    pos_r  <= pos_nxt;
    i_r    <= i_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_HIT || state_r == S_SHRD || state_r == S_SHWR))
    else $error("table write outside update or insert");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (lo_r <= hi_r && hi_r <= cnt_r))
    else $error("search window out of order");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && cnt_r != $past(cnt_r)) |->
      ($past(state_r) == S_SHRD && cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("entry count changed outside insert");
`endif

endmodule

`default_nettype wire

@@ hdl/sorted_key_accumulator_table.sv @@
// Sorted key table with per-key count, weighted sum and credit total, all
// saturating. Entries live in one table memory with a single read port and
// a registered read, so each binary search probe takes a read state and a
// compare state. An insert moves every later entry up one place, with one
// read and one write per entry, before it writes the new key. One item is in
// progress at a time; the output register lets the next word be taken while a
// result waits.
`default_nettype none

module sorted_key_accumulator_table
  import skat_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_cmd,
  input  wire logic [KEY_W-1:0]     in_record_key,
  input  wire logic [GRADE_W-1:0]   in_grade,
  input  wire logic [CRED_W-1:0]    in_credits,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [2:0]           out_status,
  output logic      [IDX_OUT_W-1:0] out_entry_index,
  output logic      [COUNT_W-1:0]   out_course_total,
  output logic      [WSUM_W-1:0]    out_weighted_total,
  output logic      [CSUM_W-1:0]    out_credit_total
);

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             out_valid_r;
  res_t             out_r;

  skat_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  skat_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_record_key (in_record_key),
    .in_grade      (in_grade),
    .in_credits    (in_credits),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_entry_index    = out_r.idx;
  assign out_course_total   = out_r.cnt;
  assign out_weighted_total = out_r.wsum;
  assign out_credit_total   = out_r.csum;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skat_pkg::*;

  localparam int SAT_REPEATS  = 30;
  localparam int RANDOM_WORDS = 900;
  localparam int LONG_HOLD    = 400;
  localparam int REPORT_CAP   = 100;
  localparam int TAIL_CYCLES  = 40;

  localparam logic [KEY_W-1:0] SAT_KEY = 27'd5000000;
  localparam logic [KEY_W-1:0] TOP_KEY = {KEY_W{1'b1}};

  typedef struct {
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
    logic [CRED_W-1:0]  credits;
    int unsigned        tx_gap;
    int unsigned        rx_gap;
  } rec_word_t;

  typedef struct {
    res_t        res;
    int unsigned rx_gap;
  } awaited_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = 1'b0;
  logic [KEY_W-1:0]     in_record_key = '0;
  logic [GRADE_W-1:0]   in_grade = '0;
  logic [CRED_W-1:0]    in_credits = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_status;
  logic [IDX_OUT_W-1:0] out_entry_index;
  logic [COUNT_W-1:0]   out_course_total;
  logic [WSUM_W-1:0]    out_weighted_total;
  logic [CSUM_W-1:0]    out_credit_total;

  sorted_key_accumulator_table u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_record_key     (in_record_key),
    .in_grade          (in_grade),
    .in_credits        (in_credits),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_entry_index   (out_entry_index),
    .out_course_total  (out_course_total),
    .out_weighted_total(out_weighted_total),
    .out_credit_total  (out_credit_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the sorted table
  logic [KEY_W-1:0]   tbl_key  [TABLE_DEPTH];
  logic [COUNT_W-1:0] tbl_cnt  [TABLE_DEPTH];
  logic [WSUM_W-1:0]  tbl_wsum [TABLE_DEPTH];
  logic [CSUM_W-1:0]  tbl_csum [TABLE_DEPTH];
  int                 keys_held = 0;
  int                 words_by_status [5] = '{default: 0};
  bit                 sat_count, sat_weight, sat_credit;

  rec_word_t   pending_words[$];
  awaited_t    awaited[$];
  rec_word_t   cur_word;
  awaited_t    exp_item;
  awaited_t    got_item;
  int unsigned tx_wait, rx_wait;
  int          errors = 0;
  int          words_taken = 0;
  int          results_seen = 0;
  bit          quiet = 1'b0;

  // generator bookkeeping, used only to pick keys
  bit          key_known [bit [KEY_W-1:0]];
  logic [KEY_W-1:0] known_keys[$];

  function automatic longint sat_add(longint a, longint b, longint top, inout bit hit_top);
    longint s;
    s = a + b;
    if (s > top) begin
      hit_top = 1'b1;
      return top;
    end
    return s;
  endfunction

  function automatic res_t table_apply(rec_word_t w);
    int     lo, hi, mid, pos, i;
    bit     hit;
    res_t   r;
    longint prod;
    lo   = 0;
    hi   = keys_held;
    hit  = 1'b0;
    pos  = 0;
    prod = longint'(w.grade) * longint'(w.credits);
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] == w.key) begin
        hit = 1'b1;
        pos = mid;
      end else if (w.key > tbl_key[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (!hit) pos = lo;
    r = '0;
    if (w.cmd == CMD_LOOKUP) begin
      r.status = hit ? ST_LOOKUP_HIT : ST_LOOKUP_MISS;
    end else if (hit) begin
      r.status = ST_UPDATED;
      tbl_cnt[pos]  = COUNT_W'(sat_add(longint'(tbl_cnt[pos]), 1, 64'hFFFF, sat_count));
      tbl_wsum[pos] = WSUM_W'(sat_add(longint'(tbl_wsum[pos]), prod, 64'hFFFF_FFFF,
                                      sat_weight));
      tbl_csum[pos] = CSUM_W'(sat_add(longint'(tbl_csum[pos]), longint'(w.credits),
                                      64'hFF_FFFF, sat_credit));
    end else if (keys_held >= TABLE_DEPTH) begin
      r.status = ST_DROPPED;
    end else begin
      for (i = keys_held; i > pos; i--) begin
        tbl_key[i]  = tbl_key[i-1];
        tbl_cnt[i]  = tbl_cnt[i-1];
        tbl_wsum[i] = tbl_wsum[i-1];
        tbl_csum[i] = tbl_csum[i-1];
      end
      tbl_key[pos]  = w.key;
      tbl_cnt[pos]  = COUNT_W'(1);
      tbl_wsum[pos] = WSUM_W'(prod);
      tbl_csum[pos] = CSUM_W'(w.credits);
      keys_held++;
      r.status = ST_INSERTED;
    end
    if (r.status != ST_DROPPED && r.status != ST_LOOKUP_MISS) begin
      r.idx  = IDX_OUT_W'(pos);
      r.cnt  = tbl_cnt[pos];
      r.wsum = tbl_wsum[pos];
      r.csum = tbl_csum[pos];
    end
    words_by_status[int'(r.status)]++;
    return r;
  endfunction

  function automatic void add_word(cmd_t c, logic [KEY_W-1:0] k, logic [GRADE_W-1:0] g,
                                   logic [CRED_W-1:0] cr);
    rec_word_t w;
    w.cmd     = c;
    w.key     = k;
    w.grade   = g;
    w.credits = cr;
    w.tx_gap  = quiet ? 0 : $urandom_range(0, 8);
    w.rx_gap  = quiet ? 0 : $urandom_range(0, 8);
    if (c == CMD_ACCUM && !key_known.exists(k) && known_keys.size() < TABLE_DEPTH) begin
      key_known[k] = 1'b1;
      known_keys.push_back(k);
    end
    pending_words.push_back(w);
  endfunction

  function automatic logic [KEY_W-1:0] some_known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  function automatic void field_check(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        exp_item.res    = table_apply(cur_word);
        exp_item.rx_gap = cur_word.rx_gap;
        awaited.push_back(exp_item);
        words_taken++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (tx_wait < pending_words[0].tx_gap) begin
          tx_wait++;
          in_valid <= 1'b0;
        end else begin
          cur_word = pending_words.pop_front();
          tx_wait  = 0;
          in_cmd        <= cur_word.cmd;
          in_record_key <= cur_word.key;
          in_grade      <= cur_word.grade;
          in_credits    <= cur_word.credits;
          in_valid      <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t ns: result expected none actual status %0d", $time, out_status);
        end else begin
          got_item = awaited.pop_front();
          field_check("status", 64'(got_item.res.status), 64'(out_status));
          field_check("entry_index", 64'(got_item.res.idx), 64'(out_entry_index));
          field_check("course_total", 64'(got_item.res.cnt), 64'(out_course_total));
          field_check("weighted_total", 64'(got_item.res.wsum), 64'(out_weighted_total));
          field_check("credit_total", 64'(got_item.res.csum), 64'(out_credit_total));
          rx_wait = got_item.rx_gap;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned roll;
    // lookup on an empty table
    add_word(CMD_LOOKUP, 27'h0001234, '0, '0);
    // one key accumulated back to back with the largest grade and credits
    quiet = 1'b1;
    repeat (SAT_REPEATS) add_word(CMD_ACCUM, SAT_KEY, 5'd31, 10'd1023);
    quiet = 1'b0;
    add_word(CMD_LOOKUP, SAT_KEY, '0, '0);
    add_word(CMD_ACCUM, SAT_KEY, '0, '0);
    // extremes and placement at either end and in the middle
    add_word(CMD_ACCUM, '0, '0, '0);
    add_word(CMD_ACCUM, TOP_KEY, 5'd31, 10'd1023);
    add_word(CMD_ACCUM, 27'd99999999, 5'd20, 10'd1000);
    add_word(CMD_ACCUM, '0, 5'd20, 10'd1000);
    add_word(CMD_ACCUM, TOP_KEY, '0, 10'd1023);
    add_word(CMD_LOOKUP, '0, '0, '0);
    add_word(CMD_LOOKUP, TOP_KEY, '0, '0);
    add_word(CMD_LOOKUP, 27'd99999999, 5'd31, 10'd1023);
    add_word(CMD_LOOKUP, 27'd99999998, '0, '0);
    add_word(CMD_ACCUM, 27'd1, 5'd1, 10'd1);
    add_word(CMD_ACCUM, 27'h5555555, 5'h15, 10'h2AA);
    add_word(CMD_ACCUM, 27'h2AAAAAA, 5'h0A, 10'h155);
    add_word(CMD_ACCUM, 27'h5555555, 5'h0A, 10'h155);
    add_word(CMD_LOOKUP, 27'd1, '0, '0);
    add_word(CMD_LOOKUP, TOP_KEY - 27'd1, '0, '0);
    add_word(CMD_ACCUM, 27'd1, 5'd31, 10'd0);

    // random mix: the table fills up part way through, then new keys are dropped
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i >= 300 && i < 380);
      roll  = $urandom_range(0, 99);
      if (roll < 30) begin
        add_word(CMD_LOOKUP,
                 ($urandom_range(0, 9) < 7) ? some_known_key() : KEY_W'($urandom),
                 GRADE_W'($urandom), CRED_W'($urandom));
      end else if (roll < 65) begin
        add_word(CMD_ACCUM, some_known_key(), GRADE_W'($urandom), CRED_W'($urandom));
      end else begin
        add_word(CMD_ACCUM, KEY_W'($urandom), GRADE_W'($urandom), CRED_W'($urandom));
      end
      // long hold at the output while words keep coming in
      if (i == 150 || i == 650) pending_words[$].rx_gap = LONG_HOLD;
      if ((i > 150 && i <= 170) || (i > 650 && i <= 670)) pending_words[$].tx_gap = 0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || awaited.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d words and %0d results, %0d keys held at the end",
             words_taken, results_seen, keys_held);
    $display("inserted %0d updated %0d dropped %0d hit %0d missed %0d, saturated %0b%0b%0b",
             words_by_status[int'(ST_INSERTED)], words_by_status[int'(ST_UPDATED)],
             words_by_status[int'(ST_DROPPED)], words_by_status[int'(ST_LOOKUP_HIT)],
             words_by_status[int'(ST_LOOKUP_MISS)], sat_count, sat_weight, sat_credit);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #80_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/skat_pkg.sv
hdl/skat_ram.sv
hdl/skat_engine.sv
hdl/sorted_key_accumulator_table.sv
test/tb.sv
